// File: design/tdc_pkg.sv
`default_nettype none

package tdc_pkg;

    // Store geometry
    localparam int MAP_MAX    = 128;
    localparam int KERNEL_MAX = 9;

    localparam int MAP_AW    = $clog2(MAP_MAX);
    localparam int MAP_W     = $clog2(MAP_MAX + 1);
    localparam int PIX_DEPTH = MAP_MAX * MAP_MAX;
    localparam int PIX_AW    = 2 * MAP_AW;
    localparam int WGT_DEPTH = KERNEL_MAX * KERNEL_MAX;
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int KSZ_W     = $clog2(KERNEL_MAX + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int COORD_W = 7;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = 40;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;

    // Signed window positions: coordinate times stride, less padding, plus tap
    localparam int POS_W = 12;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_PIXEL  = 2'd1,
        OP_COMPUTE     = 2'd2
    } op_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MAP_SIZE    = 2'd0,
        CFG_KERNEL_SIZE = 2'd1,
        CFG_STRIDE      = 2'd2,
        CFG_PADDING     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// File: design/two_d_convolution.sv
// Timing: a load is written into its store on acceptance. A compute passes setup, run
// and drain, or setup alone when out of range, before its result strobe, and no new
// command is taken until then. Run reads one tap per cycle on the single pixel-store
// read port, and taps pass read, multiply and accumulate registers in turn.
// Reset: rst_n asynchronous, active low; clears control and config (32, 3, 1, 0).
// Both stores are left as found. The receiver cannot stall: done lasts one cycle.
`default_nettype none

module two_d_convolution (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [tdc_pkg::OP_W-1:0]            op,
    input  wire logic [tdc_pkg::COORD_W-1:0]         row,
    input  wire logic [tdc_pkg::COORD_W-1:0]         col,
    input  wire logic signed [tdc_pkg::VAL_W-1:0]    value,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [tdc_pkg::CIDX_W-1:0]          cfg_index,
    input  wire logic [tdc_pkg::CFG_W-1:0]           cfg_data,
    // result beat
    output logic                                     done,
    output logic signed [tdc_pkg::SUM_W-1:0]         sum,
    output logic                                     out_of_range
);

    localparam int POS_W  = tdc_pkg::POS_W;
    localparam int KSZ_W  = tdc_pkg::KSZ_W;
    localparam int MAP_W  = tdc_pkg::MAP_W;
    localparam int MAP_AW = tdc_pkg::MAP_AW;
    localparam int WGT_AW = tdc_pkg::WGT_AW;
    localparam int PIX_AW = tdc_pkg::PIX_AW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] map_size_reg;
    logic [3:0] kernel_size_reg;
    logic [3:0] stride_reg;
    logic [2:0] padding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg    <= 8'd32;
            kernel_size_reg <= 4'd3;
            stride_reg      <= 4'd1;
            padding_reg     <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tdc_pkg::CFG_MAP_SIZE:    map_size_reg    <= cfg_data[7:0];
                tdc_pkg::CFG_KERNEL_SIZE: kernel_size_reg <= cfg_data[3:0];
                tdc_pkg::CFG_STRIDE:      stride_reg      <= cfg_data[3:0];
                tdc_pkg::CFG_PADDING:     padding_reg     <= cfg_data[2:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective geometry: saturate the map side, force an odd kernel side
    // within the store, take a zero stride as one.
    // ------------------------------------------------------------------
    logic [MAP_W-1:0]  n_eff;
    logic [KSZ_W-1:0]  k_eff;
    logic [3:0]        s_eff;
    logic signed [POS_W-1:0] span;

    always_comb
    begin
        if (map_size_reg == 8'd0)
        begin
            n_eff = MAP_W'(1);
        end
        else if (16'(map_size_reg) > 16'(tdc_pkg::MAP_MAX))
        begin
            n_eff = MAP_W'(tdc_pkg::MAP_MAX);
        end
        else
        begin
            n_eff = MAP_W'(map_size_reg);
        end

        if (kernel_size_reg > 4'(tdc_pkg::KERNEL_MAX))
        begin
            k_eff = KSZ_W'(tdc_pkg::KERNEL_MAX);
        end
        else if (kernel_size_reg == 4'd0)
        begin
            k_eff = KSZ_W'(1);
        end
        else
        begin
            k_eff = KSZ_W'(kernel_size_reg);
        end
        // drop an even side to the next lower odd one
        if (!k_eff[0])
        begin
            k_eff = k_eff - KSZ_W'(1);
        end

        s_eff = (stride_reg == 4'd0) ? 4'd1 : stride_reg;

        // padded map side less the window side; negative means no output at all
        span = signed'(POS_W'(n_eff)) + signed'(POS_W'({padding_reg, 1'b0}))
             - signed'(POS_W'(k_eff));
    end

    // ------------------------------------------------------------------
    // Command accept and load path: loads go straight into the stores
    // ------------------------------------------------------------------
    logic accept;
    assign accept = start && !busy;

    logic               wgt_we;
    logic [WGT_AW-1:0]  wgt_waddr;
    logic               pix_we;
    logic [PIX_AW-1:0]  pix_waddr;

    always_comb
    begin
        wgt_we = accept && (op == tdc_pkg::OP_LOAD_WEIGHT)
              && (32'(row) < tdc_pkg::KERNEL_MAX) && (32'(col) < tdc_pkg::KERNEL_MAX);
        pix_we = accept && (op == tdc_pkg::OP_LOAD_PIXEL)
              && (32'(row) < tdc_pkg::MAP_MAX) && (32'(col) < tdc_pkg::MAP_MAX);
        wgt_waddr = WGT_AW'(WGT_AW'(row) * WGT_AW'(tdc_pkg::KERNEL_MAX)) + WGT_AW'(col);
        pix_waddr = {MAP_AW'(row), MAP_AW'(col)};
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    tdc_pkg::state_t state_reg, state_next;

    logic [tdc_pkg::COORD_W-1:0] row_reg, col_reg;
    logic signed [POS_W-1:0]     r0_reg, r0_next;
    logic signed [POS_W-1:0]     c0_reg, c0_next;
    logic [KSZ_W-1:0]            ki_reg, ki_next;
    logic [KSZ_W-1:0]            kj_reg, kj_next;
    logic                        issue_reg, issue_next;
    logic                        tap_reg, tap_next;
    logic                        prod_v_reg;
    logic                        acc_clear;
    logic                        done_reg, done_next;
    logic                        oor_next;

    logic signed [tdc_pkg::PROD_W-1:0] prod_reg;
    logic signed [tdc_pkg::SUM_W-1:0]  acc_reg;
    logic signed [tdc_pkg::SUM_W-1:0]  sum_reg;
    logic                              oor_reg;

    // window origin and range check, worked out once per compute beat
    logic [10:0]             row_s, col_s;
    logic signed [POS_W-1:0] r0_calc, c0_calc;
    logic                    oor_calc;

    always_comb
    begin
        row_s    = 11'(row_reg) * 11'(s_eff);
        col_s    = 11'(col_reg) * 11'(s_eff);
        r0_calc  = signed'(POS_W'(row_s)) - signed'(POS_W'(padding_reg));
        c0_calc  = signed'(POS_W'(col_s)) - signed'(POS_W'(padding_reg));
        // pos < floor(span / s) + 1 holds exactly when pos * s <= span
        oor_calc = (span < 0)
                || (signed'(POS_W'(row_s)) > span)
                || (signed'(POS_W'(col_s)) > span);
    end

    // current tap position and its in-map test
    logic signed [POS_W-1:0] r_cur, c_cur;
    logic                    tap_in_map;
    logic [WGT_AW-1:0]       wgt_raddr;
    logic [PIX_AW-1:0]       pix_raddr;

    always_comb
    begin
        r_cur = r0_reg + signed'(POS_W'(ki_reg));
        c_cur = c0_reg + signed'(POS_W'(kj_reg));
        tap_in_map = (r_cur >= 0) && (r_cur < signed'(POS_W'(n_eff)))
                  && (c_cur >= 0) && (c_cur < signed'(POS_W'(n_eff)));
        wgt_raddr = WGT_AW'(WGT_AW'(ki_reg) * WGT_AW'(tdc_pkg::KERNEL_MAX))
                  + WGT_AW'(kj_reg);
        // an outside tap reads any entry; its product is dropped
        pix_raddr = {MAP_AW'(r_cur), MAP_AW'(c_cur)};
    end

    always_comb
    begin
        state_next = state_reg;
        r0_next    = r0_reg;
        c0_next    = c0_reg;
        ki_next    = ki_reg;
        kj_next    = kj_reg;
        issue_next = 1'b0;
        tap_next   = 1'b0;
        acc_clear  = 1'b0;
        done_next  = 1'b0;
        oor_next   = 1'b0;

        unique case (state_reg)
            tdc_pkg::ST_IDLE:
            begin
                if (accept && (op == tdc_pkg::OP_COMPUTE))
                begin
                    state_next = tdc_pkg::ST_SETUP;
                end
            end

            tdc_pkg::ST_SETUP:
            begin
                if (oor_calc)
                begin
                    // flag the beat at once, no taps read
                    done_next  = 1'b1;
                    oor_next   = 1'b1;
                    state_next = tdc_pkg::ST_IDLE;
                end
                else
                begin
                    r0_next    = r0_calc;
                    c0_next    = c0_calc;
                    ki_next    = '0;
                    kj_next    = '0;
                    acc_clear  = 1'b1;
                    state_next = tdc_pkg::ST_RUN;
                end
            end

            tdc_pkg::ST_RUN:
            begin
                // issue one tap read per cycle, row by row
                issue_next = 1'b1;
                tap_next   = tap_in_map;
                if (kj_reg == k_eff - KSZ_W'(1))
                begin
                    kj_next = '0;
                    ki_next = ki_reg + KSZ_W'(1);
                    if (ki_reg == k_eff - KSZ_W'(1))
                    begin
                        state_next = tdc_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    kj_next = kj_reg + KSZ_W'(1);
                end
            end

            tdc_pkg::ST_DRAIN:
            begin
                // hold until the last product has reached the accumulator
                if (!issue_reg && !prod_v_reg)
                begin
                    done_next  = 1'b1;
                    state_next = tdc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tdc_pkg::ST_IDLE;
            ki_reg     <= '0;
            kj_reg     <= '0;
            issue_reg  <= 1'b0;
            tap_reg    <= 1'b0;
            prod_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ki_reg     <= ki_next;
            kj_reg     <= kj_next;
            issue_reg  <= issue_next;
            tap_reg    <= tap_next;
            prod_v_reg <= issue_reg;
            done_reg   <= done_next;
        end
    end

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic signed [tdc_pkg::VAL_W-1:0] wgt_rdata;
    logic signed [tdc_pkg::VAL_W-1:0] pix_rdata;

    tdc_ram #(
        .WIDTH (tdc_pkg::VAL_W),
        .DEPTH (tdc_pkg::WGT_DEPTH)
    ) u_weight_store (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (value),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    tdc_ram #(
        .WIDTH (tdc_pkg::VAL_W),
        .DEPTH (tdc_pkg::PIX_DEPTH)
    ) u_pixel_store (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (value),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath: multiply in the cycle after the read, accumulate in the next
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        r0_reg   <= r0_next;
        c0_reg   <= c0_next;
        if (tap_reg)
        begin
            prod_reg <= pix_rdata * wgt_rdata;
        end
        else
        begin
            prod_reg <= '0;
        end

        if (acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + tdc_pkg::SUM_W'(prod_reg);
        end

        if (done_next)
        begin
            sum_reg <= oor_next ? '0 : acc_reg;
            oor_reg <= oor_next;
        end
    end

    assign busy         = (state_reg != tdc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign sum          = sum_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// File: design/tdc_ram.sv
`default_nettype none

module tdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;

    import tdc_pkg::*;

    // Op code 3 has no meaning to the block; name it so the stimulus can send it as noise
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Generous cycle budget: roughly 1550 beats, each with its busy time, plus long gaps
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1550;

    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic                    oor;
    } conv_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           op;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [VAL_W-1:0]   value;
    logic                      cfg_we;
    logic [CIDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      done;
    logic signed [SUM_W-1:0]   sum;
    logic                      out_of_range;

    // Shadow copy of the block: both stores, which entries hold data, and the registers
    logic signed [VAL_W-1:0]   pixel_mem  [PIX_DEPTH];
    bit                        pixel_set  [PIX_DEPTH];
    logic signed [VAL_W-1:0]   weight_mem [WGT_DEPTH];
    bit                        weight_set [WGT_DEPTH];
    logic [7:0]                reg_map;
    logic [3:0]                reg_kernel;
    logic [3:0]                reg_stride;
    logic [2:0]                reg_pad;

    conv_result_t              expected_sums[$];
    int                        n_errors;
    int                        n_items;
    int                        cycle_count;
    bit                        no_idle;

    two_d_convolution i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .row          (row),
        .col          (col),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .sum          (sum),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake must not keep the run alive forever
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: run timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Effective geometry: saturate and round the raw registers the way
    // the block does, so that odd settings are still predictable
    // ------------------------------------------------------------------
    function automatic int eff_map();
        if (reg_map == 8'd0)
            return 1;
        if (int'(reg_map) > MAP_MAX)
            return MAP_MAX;
        return int'(reg_map);
    endfunction

    function automatic int eff_kernel();
        int k;
        k = int'(reg_kernel);
        if (k == 0)
            k = 1;
        if (k > KERNEL_MAX)
            k = KERNEL_MAX;
        // Even sizes drop to the next lower odd size
        if ((k % 2) == 0)
            k = k - 1;
        return k;
    endfunction

    function automatic int eff_stride();
        return (reg_stride == 4'd0) ? 1 : int'(reg_stride);
    endfunction

    // Output side; zero when the window does not fit the padded map at all
    function automatic int out_side();
        int span;
        span = eff_map() + 2 * int'(reg_pad) - eff_kernel();
        return (span < 0) ? 0 : span / eff_stride() + 1;
    endfunction

    // Exact window sum at one output position, or the out-of-range answer
    function automatic conv_result_t predict_window(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
        conv_result_t res;
        longint       acc;
        int           n, k, s, p, side, r0, c0, pr, pc;
        n    = eff_map();
        k    = eff_kernel();
        s    = eff_stride();
        p    = int'(reg_pad);
        side = out_side();
        res.total = '0;
        res.oor   = 1'b1;
        if (int'(r) >= side || int'(c) >= side)
            return res;
        acc = 0;
        r0  = int'(r) * s - p;
        c0  = int'(c) * s - p;
        for (int ki = 0; ki < k; ki++)
        begin
            pr = r0 + ki;
            if (pr < 0 || pr >= n)
                continue;
            for (int kj = 0; kj < k; kj++)
            begin
                pc = c0 + kj;
                if (pc < 0 || pc >= n)
                    continue;
                acc += longint'(weight_mem[ki * KERNEL_MAX + kj]) *
                       longint'(pixel_mem[pr * MAP_MAX + pc]);
            end
        end
        res.total = acc[SUM_W-1:0];
        res.oor   = 1'b0;
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[VAL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender idling: mostly short gaps, now and then a long one, and whole
    // phases with none at all. Put junk on the fields while start is low.
    // ------------------------------------------------------------------
    task automatic sender_gap();
        int n, pick;
        n    = 0;
        pick = $urandom_range(0, 99);
        if (!no_idle)
        begin
            if (pick < 50)
                n = 0;
            else if (pick < 88)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 60);
        end
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            op    <= OP_W'($urandom_range(0, 3));
            row   <= COORD_W'($urandom_range(0, 127));
            col   <= COORD_W'($urandom_range(0, 127));
            value <= rand16();
        end
    endtask

    // Send one beat: hold it on the command ports until the block takes it,
    // then advance the shadow state and queue any expected result
    task automatic issue(input logic [OP_W-1:0]    opc,
                         input logic [COORD_W-1:0] r,
                         input logic [COORD_W-1:0] c,
                         input logic [VAL_W-1:0]   v);
        @(negedge clk);
        start <= 1'b1;
        op    <= opc;
        row   <= r;
        col   <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (opc)
            OP_LOAD_WEIGHT:
            begin
                // Loads outside the weight store are dropped by the block
                if (int'(r) < KERNEL_MAX && int'(c) < KERNEL_MAX)
                begin
                    weight_mem[int'(r) * KERNEL_MAX + int'(c)] = v;
                    weight_set[int'(r) * KERNEL_MAX + int'(c)] = 1'b1;
                    n_items++;
                end
            end
            OP_LOAD_PIXEL:
            begin
                pixel_mem[int'(r) * MAP_MAX + int'(c)] = v;
                pixel_set[int'(r) * MAP_MAX + int'(c)] = 1'b1;
                n_items++;
            end
            OP_COMPUTE:
            begin
                expected_sums.push_back(predict_window(r, c));
                n_items++;
            end
            default:
            begin
            end
        endcase
        sender_gap();
    endtask

    // Compute at one position. Every store entry the window will read is
    // loaded first if it has never been written; with overwrite set, every
    // such entry is loaded with fill_val regardless.
    task automatic compute_at(input logic [COORD_W-1:0] r,
                              input logic [COORD_W-1:0] c,
                              input bit                 overwrite,
                              input logic [VAL_W-1:0]   fill_val);
        int k, n, s, p, pr, pc, side;
        k    = eff_kernel();
        n    = eff_map();
        s    = eff_stride();
        p    = int'(reg_pad);
        side = out_side();
        if (int'(r) < side && int'(c) < side)
        begin
            for (int ki = 0; ki < k; ki++)
                for (int kj = 0; kj < k; kj++)
                    if (overwrite || !weight_set[ki * KERNEL_MAX + kj])
                        issue(OP_LOAD_WEIGHT, COORD_W'(ki), COORD_W'(kj),
                              overwrite ? fill_val : rand16());
            for (int ki = 0; ki < k; ki++)
            begin
                pr = int'(r) * s - p + ki;
                if (pr < 0 || pr >= n)
                    continue;
                for (int kj = 0; kj < k; kj++)
                begin
                    pc = int'(c) * s - p + kj;
                    if (pc < 0 || pc >= n)
                        continue;
                    if (overwrite || !pixel_set[pr * MAP_MAX + pc])
                        issue(OP_LOAD_PIXEL, COORD_W'(pr), COORD_W'(pc),
                              overwrite ? fill_val : rand16());
                end
            end
        end
        // The value field is meaningless here, so drive noise on it
        issue(OP_COMPUTE, r, c, rand16());
    endtask

    // Wait for the block to go quiet: no result pending, not busy, then a
    // few spare cycles so a trailing load has surely landed
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_sums.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_MAP_SIZE:    reg_map    = data;
            CFG_KERNEL_SIZE: reg_kernel = data[3:0];
            CFG_STRIDE:      reg_stride = data[3:0];
            CFG_PADDING:     reg_pad    = data[2:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_index <= CIDX_W'($urandom_range(0, 3));
        cfg_data  <= CFG_W'($urandom_range(0, 255));
    endtask

    // Reprogram all four registers while idle; the unused high bits of the
    // narrow registers carry junk, which the block must drop
    task automatic set_geometry(input logic [7:0] m, input logic [3:0] k,
                                input logic [3:0] s, input logic [2:0] p);
        logic [7:0] junk;
        settle();
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_MAP_SIZE, m);
        write_reg(CFG_KERNEL_SIZE, {junk[7:4], k});
        write_reg(CFG_STRIDE, {junk[3:0], s});
        write_reg(CFG_PADDING, {junk[4:0], p});
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done beat must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
                report($sformatf("unexpected result beat, sum %0d oor %0b",
                                 sum, out_of_range));
            else
            begin
                want = expected_sums.pop_front();
                if (sum !== want.total)
                    report($sformatf("sum %0d, expected %0d", sum, want.total));
                if (out_of_range !== want.oor)
                    report($sformatf("out_of_range %b, expected %b",
                                     out_of_range, want.oor));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry (32, 3, 1, 0): largest positive window sum, a mixed
    // sign sum, the far corner of the output, and positions beyond it
    task automatic test_reset_defaults();
        compute_at(0, 0, 1'b1, 16'h8000);
        issue(OP_LOAD_PIXEL, 1, 1, 16'h7FFF);
        issue(OP_COMPUTE, 0, 0, 16'h0000);
        compute_at(29, 29, 1'b0, '0);
        compute_at(30, 0, 1'b0, '0);
        compute_at(0, 30, 1'b0, '0);
        compute_at(127, 127, 1'b0, '0);
    endtask

    // Loads that miss the weight store and the spare op must leave no trace
    task automatic test_load_rules();
        issue(OP_LOAD_WEIGHT, 9, 0, 16'h7FFF);
        issue(OP_LOAD_WEIGHT, 0, 127, 16'h7FFF);
        issue(OP_LOAD_WEIGHT, 127, 127, 16'hFFFF);
        issue(OP_SPARE, 0, 0, 16'h1234);
        issue(OP_SPARE, 127, 127, 16'hFFFF);
        issue(OP_LOAD_PIXEL, 127, 127, 16'h8001);
        issue(OP_LOAD_PIXEL, 127, 0, 16'h0000);
        compute_at(0, 0, 1'b0, '0);
        compute_at(1, 1, 1'b0, '0);
    endtask

    // Register extremes: zero and oversize map, zero, even and oversize
    // kernel, zero and huge stride, widest padding, and a window that does
    // not fit the padded map
    task automatic test_geometry_extremes();
        set_geometry(8'd0, 4'd0, 4'd0, 3'd0);
        compute_at(0, 0, 1'b0, '0);
        compute_at(0, 1, 1'b0, '0);
        set_geometry(8'd255, 4'd15, 4'd15, 3'd7);
        compute_at(0, 0, 1'b0, '0);
        compute_at(8, 8, 1'b0, '0);
        compute_at(9, 0, 1'b0, '0);
        set_geometry(8'd1, 4'd9, 4'd1, 3'd0);
        compute_at(0, 0, 1'b0, '0);
        set_geometry(8'd1, 4'd9, 4'd1, 3'd4);
        compute_at(0, 0, 1'b0, '0);
        set_geometry(8'd129, 4'd8, 4'd0, 3'd3);
        compute_at(127, 127, 1'b0, '0);
        compute_at(0, 127, 1'b0, '0);
        set_geometry(8'd2, 4'd2, 4'd8, 3'd0);
        compute_at(0, 0, 1'b0, '0);
        // Full 9x9 kernel at the most negative value: largest exact sum
        set_geometry(8'd128, 4'd9, 4'd8, 3'd0);
        compute_at(14, 14, 1'b1, 16'h8000);
        compute_at(15, 14, 1'b0, '0);
    endtask

    // Random phases: a fresh geometry each time, then a mix of computes
    // (mostly in range), loads and noise until the beat budget is spent
    task automatic test_random_traffic();
        int         pick, beats, side, k, n;
        logic [7:0] m;
        logic [3:0] kr, sr;
        logic [6:0] r, c;
        while (n_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                m = 8'($urandom_range(1, 20));
            else if (pick < 90)
                m = 8'($urandom_range(1, 128));
            else
                m = 8'($urandom_range(0, 255));
            kr = 4'(($urandom_range(0, 99) < 60) ? 2 * $urandom_range(0, 4) + 1
                                                 : $urandom_range(0, 15));
            sr = 4'(($urandom_range(0, 99) < 70) ? $urandom_range(1, 3)
                                                 : $urandom_range(0, 15));
            set_geometry(m, kr, sr, 3'($urandom_range(0, 7)));
            no_idle = ($urandom_range(0, 99) < 25);
            side    = out_side();
            k       = eff_kernel();
            n       = eff_map();
            beats   = $urandom_range(40, 150);
            for (int i = 0; i < beats && n_items < ITEM_TARGET; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    if (side > 0 && $urandom_range(0, 99) < 85)
                    begin
                        // Favour the border rows and columns of the output
                        r = COORD_W'(($urandom_range(0, 3) == 0)
                                     ? (($urandom_range(0, 1) == 0) ? 0 : side - 1)
                                     : $urandom_range(0, side - 1));
                        c = COORD_W'(($urandom_range(0, 3) == 0)
                                     ? (($urandom_range(0, 1) == 0) ? 0 : side - 1)
                                     : $urandom_range(0, side - 1));
                    end
                    else
                    begin
                        r = COORD_W'($urandom_range(0, 127));
                        c = COORD_W'($urandom_range(0, 127));
                    end
                    compute_at(r, c, 1'b0, '0);
                end
                else if (pick < 70)
                    issue(OP_LOAD_PIXEL, COORD_W'($urandom_range(0, n - 1)),
                          COORD_W'($urandom_range(0, n - 1)), rand16());
                else if (pick < 85)
                    issue(OP_LOAD_WEIGHT, COORD_W'($urandom_range(0, k - 1)),
                          COORD_W'($urandom_range(0, k - 1)), rand16());
                else if (pick < 93)
                    issue(($urandom_range(0, 1) == 0) ? OP_SPARE : OP_LOAD_WEIGHT,
                          COORD_W'($urandom_range(9, 127)), COORD_W'($urandom_range(0, 127)),
                          rand16());
                else
                    issue(OP_LOAD_PIXEL, COORD_W'($urandom_range(0, 127)),
                          COORD_W'($urandom_range(0, 127)), rand16());
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value from time zero
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_LOAD_WEIGHT;
        row         = '0;
        col         = '0;
        value       = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MAP_SIZE;
        cfg_data    = '0;
        n_errors    = 0;
        n_items     = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        // Register values after reset; both stores start out unwritten
        reg_map     = 8'd32;
        reg_kernel  = 4'd3;
        reg_stride  = 4'd1;
        reg_pad     = 3'd0;
        for (int i = 0; i < PIX_DEPTH; i++)
        begin
            pixel_mem[i] = '0;
            pixel_set[i] = 1'b0;
        end
        for (int i = 0; i < WGT_DEPTH; i++)
        begin
            weight_mem[i] = '0;
            weight_set[i] = 1'b0;
        end

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_load_rules();
        test_geometry_extremes();
        test_random_traffic();

        // Drain: wait out every pending result, then hold long enough that
        // a stray extra beat from the slowest window would still show up
        settle();
        repeat (2 * WGT_DEPTH)
            @(posedge clk);

        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: two_d_convolution.f
design/tdc_pkg.sv
design/tdc_ram.sv
design/two_d_convolution.sv
tb/tb_top.sv
